// File: design/qse_pkg.sv
`timescale 1ns / 1ps

package qse_pkg;

    // Default configuration of the engine.
    localparam int MAX_ITEMS_DEF  = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Width of the value fields on the ports.
    localparam int FIELD_BITS = 32;

    // Control that the top level hands to every cell in the chain.
    typedef struct packed {
        logic insert;   // a new element enters the chain this cycle
        logic shift;    // the chain moves one place toward cell 0
    } t_cell_ctl;

endpackage

// File: design/qse_cell.sv
`timescale 1ns / 1ps

module qse_cell #(
    parameter int VALUE_BITS = qse_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  qse_pkg::t_cell_ctl           i_ctl,
    input  logic signed [VALUE_BITS-1:0] i_new_val,
    input  logic signed [VALUE_BITS-1:0] i_prev_val,
    input  logic                         i_prev_vld,
    input  logic                         i_prev_take,
    input  logic signed [VALUE_BITS-1:0] i_next_val,
    input  logic                         i_next_vld,
    output logic signed [VALUE_BITS-1:0] o_val,
    output logic                         o_vld,
    output logic                         o_take
);

    import qse_pkg::*;

    logic signed [VALUE_BITS-1:0] r_val;
    logic signed [VALUE_BITS-1:0] n_val;
    logic                         r_vld;
    logic                         n_vld;

    // An empty cell counts as holding plus infinity, so the take flags along
    // the chain read 0..0 1..1 and the new element lands at the first 1.
    assign o_take = !r_vld || (i_new_val < r_val);

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_ctl.shift) begin
            n_val = i_next_val;
            n_vld = i_next_vld;
        end else if (i_ctl.insert && o_take) begin
            // Either the new element settles here, or this cell takes over the
            // content of its lower neighbor, which moves up one place.
            n_val = i_prev_take ? i_prev_val : i_new_val;
            n_vld = i_prev_take ? i_prev_vld : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_vld = r_vld;

endmodule

// File: design/quicksort_engine.sv
`timescale 1ns / 1ps

// Sorting engine for batches of up to MAX_ITEMS signed values. Values arrive
// one transaction at a time on the input channel; the transaction marked last
// closes the batch. Each accepted value is inserted, in the cycle it arrives,
// into a chain of MAX_ITEMS cells that always holds the loaded values in
// ascending order, so no separate sort phase follows the load. The cycle after
// the last transaction the sorted values start to leave from cell 0 at one
// result transaction per cycle, as fast as the receiver takes them; the final
// one carries last_out. The pace of load and drain is set by the single
// insertion port of the chain and the single exit at its low end. The input
// channel stalls while a batch drains. Values beyond MAX_ITEMS are discarded
// (a discarded last value still closes the batch) and every result of such a
// batch carries dropped. Values are kept and compared at VALUE_BITS bits:
// wider settings sign-extend the input, narrower ones keep its low bits, and
// results show the low 32 bits of the stored pattern, zero-extended when
// VALUE_BITS is under 32.
module quicksort_engine #(
    parameter int MAX_ITEMS  = qse_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_BITS = qse_pkg::VALUE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [qse_pkg::FIELD_BITS-1:0] i_value,
    input  logic                                  i_last,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [qse_pkg::FIELD_BITS-1:0] o_sorted_value,
    output logic                                  o_last_out,
    output logic                                  o_dropped
);

    import qse_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    // Engine phases: collecting a batch, or handing the sorted batch out.
    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_ovf;
    logic               n_ovf;

    logic               in_acc;
    logic               out_acc;
    logic               full;
    t_cell_ctl          ctl;

    logic signed [VALUE_BITS-1:0] new_val;
    logic signed [VALUE_BITS-1:0] cell_val [MAX_ITEMS];
    logic                         cell_vld [MAX_ITEMS];
    logic                         cell_take[MAX_ITEMS];

    // Bring the input word to the internal width.
    generate
        if (VALUE_BITS > FIELD_BITS) begin : g_ext
            assign new_val = {{(VALUE_BITS - FIELD_BITS){i_value[FIELD_BITS-1]}}, i_value};
            assign o_sorted_value = cell_val[0][FIELD_BITS-1:0];
        end else if (VALUE_BITS == FIELD_BITS) begin : g_same
            assign new_val = i_value;
            assign o_sorted_value = cell_val[0];
        end else begin : g_trunc
            assign new_val = i_value[VALUE_BITS-1:0];
            assign o_sorted_value = {{(FIELD_BITS - VALUE_BITS){1'b0}}, cell_val[0]};
        end
    endgenerate

    // Handshakes. While draining, cell 0 always holds the next result since a
    // batch never closes empty.
    assign o_in_stall  = (r_state == ST_DRAIN);
    assign o_out_valid = (r_state == ST_DRAIN);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign full        = (r_count == CNT_W'(MAX_ITEMS));

    assign ctl.insert  = in_acc && !full;
    assign ctl.shift   = out_acc;

    // The result in cell 0 is the final one when nothing stands behind it.
    assign o_last_out  = !cell_vld[1];
    assign o_dropped   = r_ovf;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_acc && o_last_out) begin
                    n_state = ST_LOAD;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // The chain of cells. Cell 0 holds the smallest value. On insertion each
    // cell looks at its lower neighbor; on a drain step it takes the content
    // of its upper neighbor, and the top cell empties.
    generate
        for (genvar gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            logic signed [VALUE_BITS-1:0] prev_val;
            logic                         prev_vld;
            logic                         prev_take;
            logic signed [VALUE_BITS-1:0] next_val;
            logic                         next_vld;

            if (gi == 0) begin : g_low
                assign prev_val  = new_val;
                assign prev_vld  = 1'b1;
                assign prev_take = 1'b1;
            end else begin : g_mid
                assign prev_val  = cell_val[gi-1];
                assign prev_vld  = cell_vld[gi-1];
                assign prev_take = cell_take[gi-1];
            end

            if (gi == MAX_ITEMS - 1) begin : g_top
                assign next_val = new_val;
                assign next_vld = 1'b0;
            end else begin : g_below
                assign next_val = cell_val[gi+1];
                assign next_vld = cell_vld[gi+1];
            end

            qse_cell #(
                .VALUE_BITS(VALUE_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_new_val  (new_val),
                .i_prev_val (prev_val),
                .i_prev_vld (prev_vld),
                .i_prev_take(prev_take),
                .i_next_val (next_val),
                .i_next_vld (next_vld),
                .o_val      (cell_val[gi]),
                .o_vld      (cell_vld[gi]),
                .o_take     (cell_take[gi])
            );
        end
    endgenerate

endmodule

// File: design/qse_chk.sv
`timescale 1ns / 1ps

module qse_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  i_last,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [qse_pkg::FIELD_BITS-1:0] o_sorted_value,
    input logic                                  o_last_out,
    input logic                                  o_dropped
);

    import qse_pkg::*;

    // No input transaction is taken while results are pending.
    a_no_load_in_drain: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall
    ) else $error("input accepted while results are pending");

    // An accepted last input starts the result stream in the next cycle.
    a_drain_follows_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last) |=> o_out_valid
    ) else $error("no results after the closing input");

    // The stream ends right after its final transaction.
    a_stream_ends: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_out) |=> !o_out_valid
    ) else $error("results continue past the final one");

    // Within one batch the stream does not break and the drop flag holds.
    a_batch_flag: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_out) |=>
            (o_out_valid && $stable(o_dropped))
    ) else $error("result stream broke or drop flag changed within a batch");

    // A stalled result holds.
    a_stall_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_sorted_value) && $stable(o_last_out))
    ) else $error("stalled result changed");

endmodule

bind quicksort_engine qse_chk u_qse_chk (.*);
